FILE: rtl/core/spsir_pkg.sv
package spsir_pkg;

  localparam int unsigned STATE_W     = 32;
  localparam int unsigned KEY_W       = 2 * STATE_W;
  localparam int unsigned SMALL_W     = 16;
  localparam int unsigned COUNT_OUT_W = 11;
  localparam int unsigned DEF_CAPACITY = 1024;
  localparam int unsigned GROUP_W     = 32;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // per-cycle command to every cell of the row
  typedef struct packed {
    logic cap;   // register compare result against the key
    logic ins;   // open a slot at the insert point, shift up
    logic rem;   // close the gap at the match, shift down
  } cell_ctrl_t;

endpackage

FILE: rtl/core/spsir_cell.sv
module spsir_cell import spsir_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 11
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [KEY_W-1:0] key,
  input  logic [CNT_W-1:0] count,
  input  logic [KEY_W-1:0] prev_entry,
  input  logic             prev_lt,
  input  logic [KEY_W-1:0] next_entry,
  output logic [KEY_W-1:0] entry,
  output logic             lt,
  output logic             eq
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [KEY_W-1:0] entry_r, entry_nxt;
  logic             lt_r, eq_r;
  logic             valid;

  assign valid = count > IDX_C;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (!lt_r) entry_nxt = prev_lt ? key : prev_entry;
    end else if (ctrl.rem) begin
      if (!lt_r) entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cap) begin
      lt_r <= valid && (entry_r < key);
      eq_r <= valid && (entry_r == key);
    end
    if (ctrl.ins || ctrl.rem) begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

FILE: rtl/core/spsir_found_tree.sv
module spsir_found_tree import spsir_pkg::*; #(
  parameter int unsigned N = DEF_CAPACITY
) (
  input  logic         clk,
  input  logic [N-1:0] hit,
  output logic         found
);

  localparam int unsigned NGRP = (N + GROUP_W - 1) / GROUP_W;

  logic [NGRP*GROUP_W-1:0] hit_pad;
  logic [NGRP-1:0]         grp_r;
  logic                    found_r;

  always_comb begin
    hit_pad        = '0;
    hit_pad[N-1:0] = hit;
  end

  // two registered OR levels: groups, then across groups
  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_r[g] <= |hit_pad[g*GROUP_W +: GROUP_W];
    end
    found_r <= |grp_r;
  end

  assign found = found_r;

endmodule

FILE: rtl/core/sorted_pair_set_insert_remove.sv
// Sorted set of unique (first_state, second_state) pairs, ordered by first
// then second number, held in a row of compare/shift cells.
// Input: present a word on in_* with start high; it is taken at a rising
// edge where start is high and busy is low. busy stays high until the
// result is produced.
// Output: one result word per request on out_* for exactly one cycle,
// marked by out_valid. The receiver cannot stall; it must take the word.
// Sequence: after the accept edge the request passes compare, two
// levels of the registered match OR tree, then the shift/update state.
// A new request is taken only once the last result is produced, as the
// match tree's result must be known before any cell may shift.
// Every cell compares its entry with the key in parallel; insert moves
// entries at and above the sorted position up one cell, remove moves
// entries above the match down one cell, both in the shift/update state.
// Reset: entry count 0, small flag 1, no result pending. The entries are
// not cleared; only cells below the count are ever used.
// out_entry_count is the count truncated to 11 bits.
module sorted_pair_set_insert_remove import spsir_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_req_type,
  input  logic [STATE_W-1:0]     in_first_state,
  input  logic [STATE_W-1:0]     in_second_state,
  input  logic                   in_skip_small_check,
  // result channel
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic [COUNT_OUT_W-1:0] out_entry_count,
  output logic                   out_all_small
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_RED,
    S_FND,
    S_APPLY
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 small_r, small_nxt;
  logic                 req_r, skip_r;
  logic [KEY_W-1:0]     key_r;
  logic                 out_valid_r;
  status_t              status_r, status_nxt;
  logic [COUNT_OUT_W-1:0] out_count_r;

  cell_ctrl_t           ctrl;
  logic                 found;
  logic                 do_ins, do_rem;
  logic                 key_small;

  logic [KEY_W-1:0]     ent   [CAPACITY];
  logic [CAPACITY-1:0]  lt_v, eq_v;

  wire accept = start && !busy;

  // ---------------------------------------------------------------------
  // row of cells; cell i holds entry i of the sorted order
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] prev_e, next_e;
    logic             prev_l;
    if (i == 0) begin : g_first
      assign prev_e = key_r;
      assign prev_l = 1'b1;   // nothing below: insert point if not less
    end else begin : g_mid
      assign prev_e = ent[i-1];
      assign prev_l = lt_v[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_e = ent[i];
    end else begin : g_nlast
      assign next_e = ent[i+1];
    end
    spsir_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .key        (key_r),
      .count      (count_r),
      .prev_entry (prev_e),
      .prev_lt    (prev_l),
      .next_entry (next_e),
      .entry      (ent[i]),
      .lt         (lt_v[i]),
      .eq         (eq_v[i])
    );
  end

  // match among valid cells, two registered OR levels
  spsir_found_tree #(.N(CAPACITY)) u_tree (
    .clk   (clk),
    .hit   (eq_v),
    .found (found)
  );

  // ---------------------------------------------------------------------
  // decision in the update cycle
  // ---------------------------------------------------------------------
  assign key_small = (key_r[KEY_W-1 -: (STATE_W-SMALL_W)] == '0) &&
                     (key_r[STATE_W-1 -: (STATE_W-SMALL_W)] == '0);

  always_comb begin
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    count_nxt  = count_r;
    small_nxt  = small_r;
    status_nxt = ST_NOT_FOUND;
    if (req_r == REQ_REMOVE) begin
      if (found) begin
        do_rem     = 1'b1;
        count_nxt  = count_r - 1'b1;
        status_nxt = ST_REMOVED;
      end
    end else begin
      if (found) begin
        status_nxt = ST_PRESENT;
      end else if (count_r == CAP_C) begin
        status_nxt = ST_FULL;
      end else begin
        do_ins     = 1'b1;
        count_nxt  = count_r + 1'b1;
        status_nxt = ST_INSERTED;
      end
      // sticky: only ever clears
      if (status_nxt != ST_FULL && !skip_r && !key_small) small_nxt = 1'b0;
    end
  end

  always_comb begin
    ctrl.cap = (state_r == S_CMP);
    ctrl.ins = (state_r == S_APPLY) && do_ins;
    ctrl.rem = (state_r == S_APPLY) && do_rem;
  end

  // ---------------------------------------------------------------------
  // sequencer, state and result registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      small_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r   <= in_req_type;
            skip_r  <= in_skip_small_check;
            key_r   <= {in_first_state, in_second_state};
            state_r <= S_CMP;
          end
        end
        S_CMP:  state_r <= S_RED;
        S_RED:  state_r <= S_FND;
        S_FND:  state_r <= S_APPLY;
        S_APPLY: begin
          count_r     <= count_nxt;
          small_r     <= small_nxt;
          status_r    <= status_nxt;
          out_count_r <= COUNT_OUT_W'(count_nxt);
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_entry_count = out_count_r;
  assign out_all_small   = small_r;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C) else $error("entry count above capacity");

  // a reset sets the flag again, so only look where $past(rst_n) shows reset was not asserted
  a_small_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$rose(small_r)) else $error("small flag set again after clearing");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("busy low right after accept");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE) && !$past(out_valid_r))
    else $error("result strobe outside update completion");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_INSERTED) |-> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the count by one");

endmodule
